// ----- rtl/core/shc_pkg.sv -----
package shc_pkg;

    localparam int YearW  = 11;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int CountW = 17;

    localparam logic [YearW-1:0] FirstYear = 11'd1206;
    localparam logic [YearW-1:0] LastYear  = 11'd1498;
    localparam logic [YearW-1:0] LunarBase = 11'd1242;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [CountW-1:0] a;
        logic [CountW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [CountW-1:0] res;
        logic              ge;
    } alu_rsp_t;

    typedef struct packed {
        logic [YearW-1:0]  shamsi_year;
        logic [MonthW-1:0] shamsi_month;
        logic [DayW-1:0]   shamsi_day;
    } in_t;

    typedef struct packed {
        logic [CountW-1:0] day_number;
        logic [2:0]        weekday;
        logic [11:0]       gregorian_year;
        logic [3:0]        gregorian_month;
        logic [4:0]        gregorian_day;
        logic [10:0]       lunar_year;
        logic [3:0]        lunar_month;
        logic [4:0]        lunar_day;
        logic              input_ok;
    } out_t;

endpackage

// ----- rtl/core/shc_alu.sv -----
module shc_alu (
    input  shc_pkg::alu_req_t req,
    output shc_pkg::alu_rsp_t rsp
);
    import shc_pkg::*;

    logic [CountW:0] sum;

    // Subtract as add of the complement; carry out means no borrow.
    always_comb
    begin
        if (req.op == ALU_SUB)
        begin
            sum = {1'b0, req.a} + {1'b0, ~req.b} + {{CountW{1'b0}}, 1'b1};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res = sum[CountW-1:0];
        rsp.ge  = (req.op == ALU_SUB) && sum[CountW];
    end

endmodule

// ----- rtl/core/solar_hijri_date_converter.sv -----
// Solar Hijri date converter.
// Input channel in_valid/in_ready/in_data carries one Solar Hijri date per
// transaction. Output channel out_valid/out_ready/out_data carries one result
// per input: day count since 1206-01-01, weekday (0 = Saturday), Gregorian
// date and tabular lunar Hijri date, plus input_ok.
// The day-count additions and subtractions go through one shared 17-bit
// add/subtract unit under a small sequencer. Per date it accepts the input,
// adds one solar year at a time from 1206, adds the month, the day and an
// offset, runs a restoring mod-7 reduction, rebases for the lunar search,
// steps lunar years from 1242 (about 300 at most), takes one to twelve
// month steps, then loads the output register.
// A date that fails the range checks skips the conversion and finishes with all fields 0.
// in_ready is high only while the sequencer is idle; it is not held off by a
// full output register, so a new date may start while the previous result
// waits. If the receiver stalls, the finished result waits in the sequencer
// until the output register frees up. Reset empties the output register and
// returns the sequencer to idle.
module solar_hijri_date_converter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  shc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output shc_pkg::out_t out_data
);
    import shc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YEAR,
        S_MON,
        S_DAY,
        S_W5,
        S_WEEK,
        S_L229,
        S_LYEAR,
        S_LMON,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [4:0] thresh;
        logic [3:0] m_before;
        logic [4:0] add;
        logic [3:0] m_after;
        logic [4:0] sub;
    } greg_row_t;

    // Days in the solar months before month m.
    function automatic logic [8:0] mon_off(input logic [MonthW-1:0] m);
        logic [8:0] r;
        r = 9'd0;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd62;
            4'd4:    r = 9'd93;
            4'd5:    r = 9'd124;
            4'd6:    r = 9'd155;
            4'd7:    r = 9'd186;
            4'd8:    r = 9'd216;
            4'd9:    r = 9'd246;
            4'd10:   r = 9'd276;
            4'd11:   r = 9'd306;
            4'd12:   r = 9'd336;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic greg_row_t greg_row(input logic [MonthW-1:0] m);
        greg_row_t r;
        r = '0;
        case (m)
            4'd1:    r = '{5'd12, 4'd3,  5'd20, 4'd4,  5'd11};
            4'd2:    r = '{5'd11, 4'd4,  5'd20, 4'd5,  5'd10};
            4'd3:    r = '{5'd11, 4'd5,  5'd21, 4'd6,  5'd10};
            4'd4:    r = '{5'd10, 4'd6,  5'd21, 4'd7,  5'd9};
            4'd5:    r = '{5'd10, 4'd7,  5'd22, 4'd8,  5'd9};
            4'd6:    r = '{5'd10, 4'd8,  5'd22, 4'd9,  5'd9};
            4'd7:    r = '{5'd9,  4'd9,  5'd22, 4'd10, 5'd8};
            4'd8:    r = '{5'd10, 4'd10, 5'd22, 4'd11, 5'd9};
            4'd9:    r = '{5'd10, 4'd11, 5'd21, 4'd12, 5'd9};
            4'd10:   r = '{5'd11, 4'd12, 5'd21, 4'd1,  5'd10};
            4'd11:   r = '{5'd12, 4'd1,  5'd20, 4'd2,  5'd11};
            4'd12:   r = '{5'd11, 4'd2,  5'd19, 4'd3,  5'd10};
            default: r = '0;
        endcase
        return r;
    endfunction

    state_t              state_reg;
    logic [YearW-1:0]    y_reg;
    logic [MonthW-1:0]   m_reg;
    logic [DayW-1:0]     d_reg;
    logic                ok_reg;
    logic [YearW-1:0]    yr_reg;     // solar year walker, later lunar year
    logic [5:0]          c33_reg;    // (year - 1210) mod 33
    logic [4:0]          frac_reg;   // lunar leap fraction, mod 30
    logic [3:0]          k_reg;      // mod-7 reduction bit
    logic [MonthW-1:0]   lm_reg;
    logic [CountW-1:0]   acc_reg;
    logic [CountW-1:0]   cnt_reg;
    logic [2:0]          wd_reg;
    logic                out_valid_reg;
    out_t                out_reg;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic                leap;
    logic                lcarry;
    logic [CountW-1:0]   wsel;
    logic                out_load;
    greg_row_t           gr;
    out_t                result;

    shc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Leap years fall every fourth year in each 33-year cycle from 1210.
    assign leap   = (c33_reg[1:0] == 2'd0) && (c33_reg <= 6'd28);
    assign lcarry = (frac_reg >= 5'd19);
    assign wsel   = alu_rsp.ge ? alu_rsp.res : acc_reg;

    // Load the finished result once the output register is free.
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        alu_req.op = ALU_ADD;
        alu_req.a  = acc_reg;
        alu_req.b  = '0;
        unique case (state_reg)
            S_YEAR:  alu_req.b = leap ? CountW'(366) : CountW'(365);
            S_MON:   alu_req.b = CountW'(mon_off(m_reg));
            S_DAY:   alu_req.b = CountW'(d_reg - 5'd1);
            S_W5:    alu_req.b = CountW'(5);
            S_WEEK:
            begin
                alu_req.op = ALU_SUB;
                alu_req.b  = CountW'(7) << k_reg;
            end
            S_L229:
            begin
                alu_req.a = cnt_reg;
                alu_req.b = CountW'(229);
            end
            S_LYEAR:
            begin
                alu_req.op = ALU_SUB;
                alu_req.b  = lcarry ? CountW'(355) : CountW'(354);
            end
            S_LMON:
            begin
                alu_req.op = ALU_SUB;
                alu_req.b  = lm_reg[0] ? CountW'(30) : CountW'(29);
            end
            default: alu_req.b = '0;
        endcase
    end

    // Assemble the finished result from the working registers.
    always_comb
    begin
        gr     = greg_row(m_reg);
        result = '0;
        if (ok_reg)
        begin
            result.day_number = cnt_reg;
            result.weekday    = wd_reg;
            result.input_ok   = 1'b1;
            if (d_reg < gr.thresh)
            begin
                result.gregorian_month = gr.m_before;
                result.gregorian_day   = d_reg + gr.add;
            end
            else
            begin
                result.gregorian_month = gr.m_after;
                result.gregorian_day   = d_reg - gr.sub;
            end
            if ((m_reg == 4'd10 && d_reg >= 5'd11) || m_reg >= 4'd11)
            begin
                result.gregorian_year = {1'b0, y_reg} + 12'd622;
            end
            else
            begin
                result.gregorian_year = {1'b0, y_reg} + 12'd621;
            end
            result.lunar_year  = yr_reg;
            result.lunar_month = lm_reg;
            result.lunar_day   = acc_reg[4:0] + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            ok_reg        <= 1'b0;
            y_reg         <= '0;
            m_reg         <= '0;
            d_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            wd_reg        <= '0;
            c33_reg       <= '0;
            k_reg         <= '0;
            lm_reg        <= '0;
            frac_reg      <= '0;
            yr_reg        <= '0;
        end
        else
        begin
            // Raise valid on a load, drop it once taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        y_reg   <= in_data.shamsi_year;
                        m_reg   <= in_data.shamsi_month;
                        d_reg   <= in_data.shamsi_day;
                        acc_reg <= '0;
                        yr_reg  <= FirstYear;
                        c33_reg <= 6'd29;
                        if (in_data.shamsi_year >= FirstYear
                            && in_data.shamsi_year <= LastYear
                            && in_data.shamsi_month >= 4'd1
                            && in_data.shamsi_month <= 4'd12
                            && in_data.shamsi_day >= 5'd1)
                        begin
                            ok_reg    <= 1'b1;
                            state_reg <= S_YEAR;
                        end
                        else
                        begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_YEAR:
                begin
                    if (yr_reg == y_reg)
                    begin
                        state_reg <= S_MON;
                    end
                    else
                    begin
                        acc_reg <= alu_rsp.res;
                        yr_reg  <= yr_reg + 11'd1;
                        c33_reg <= (c33_reg == 6'd32) ? 6'd0 : c33_reg + 6'd1;
                    end
                end
                S_MON:
                begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= S_DAY;
                end
                S_DAY:
                begin
                    acc_reg   <= alu_rsp.res;
                    cnt_reg   <= alu_rsp.res;
                    state_reg <= S_W5;
                end
                S_W5:
                begin
                    acc_reg   <= alu_rsp.res;
                    k_reg     <= 4'd14;
                    state_reg <= S_WEEK;
                end
                S_WEEK:
                begin
                    acc_reg <= wsel;
                    k_reg   <= k_reg - 4'd1;
                    if (k_reg == 4'd0)
                    begin
                        wd_reg    <= wsel[2:0];
                        state_reg <= S_L229;
                    end
                end
                S_L229:
                begin
                    // Offset into lunar year 1242, which starts 229 days early.
                    acc_reg   <= alu_rsp.res;
                    yr_reg    <= LunarBase;
                    frac_reg  <= 5'd15;
                    state_reg <= S_LYEAR;
                end
                S_LYEAR:
                begin
                    if (alu_rsp.ge)
                    begin
                        acc_reg  <= alu_rsp.res;
                        yr_reg   <= yr_reg + 11'd1;
                        frac_reg <= lcarry ? frac_reg - 5'd19 : frac_reg + 5'd11;
                    end
                    else
                    begin
                        lm_reg    <= 4'd1;
                        state_reg <= S_LMON;
                    end
                end
                S_LMON:
                begin
                    if (lm_reg != 4'd12 && alu_rsp.ge)
                    begin
                        acc_reg <= alu_rsp.res;
                        lm_reg  <= lm_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free.
                    if (out_load)
                    begin
                        out_reg   <= result;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer stayed idle after accepting a date");

    a_bad_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.input_ok |->
            out_data.day_number == '0 && out_data.lunar_year == '0
            && out_data.gregorian_year == '0 && out_data.weekday == '0)
        else $error("rejected date carries nonzero fields");

    a_good_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.input_ok |->
            out_data.weekday <= 3'd6 && out_data.lunar_month >= 4'd1
            && out_data.lunar_month <= 4'd12 && out_data.lunar_day >= 5'd1
            && out_data.lunar_day <= 5'd30)
        else $error("converted fields out of range");

    a_lm_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LMON |-> lm_reg >= 4'd1 && lm_reg <= 4'd12)
        else $error("lunar month walker out of range");

    a_c33_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_YEAR |-> c33_reg <= 6'd32)
        else $error("33-year cycle counter out of range");

endmodule
